// File: src/bb3_pkg.sv
// Shared constants, register codes and control types for the 3x3 box blur.
// Used by every module of the block; no dependencies.
package bb3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int IN_BITS        = 16;
  localparam int COL_OUT_W      = 10;
  localparam int ROW_W          = 12;
  localparam int WIDTH_W        = 11;
  localparam int HEIGHT_W       = 13;
  localparam int MAX_HEIGHT     = 4096;
  localparam int WIDTH_RST      = 640;
  localparam int HEIGHT_RST     = 480;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int OUT_DATA_W     = 40;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // results owed by one pixel, in emission order a, b, c
  typedef struct packed {
    logic need_c;    // current pixel, first or last row
    logic need_b;    // last column of previous row
    logic need_a;    // delayed pixel of previous row
    logic a_direct;  // delayed pixel sits in the left border column
  } res_ctl_t;

  function automatic int eff_pix_bits(int n);
    return (n < IN_BITS) ? n : IN_BITS;
  endfunction

endpackage

// File: src/box_blur_3x3.sv
// 3x3 box blur over a raster pixel stream: counters, line stores, window cells.
// Depends on bb3_pkg, bb3_cell and bb3_emit.
//
// Channel   Dir   Handshake             Payload
// s_axis    in    tvalid/tready         tdata: pixel_value
// m_axis    out   tvalid/tready/tlast   tdata: out_value, out_column, out_row
// cfg       in    cfg_valid/cfg_ready   cfg_index_i, cfg_data_i
//
// One pixel per clock when each pixel owes at most one result and m_axis is
// not stalled; the single output port limits rows that owe two or three (last
// row, row ends). From input transfer to first result: line store read, sum,
// divide by nine via reciprocal multiply, each registered in its own stage.
// Reset clears counters, window cells and pipeline valids; line stores are not
// cleared. A stalled output back-pressures through the pipeline to s_axis.
module box_blur_3x3 #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bb3_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] pixel_value
  input  logic [bb3_pkg::IN_BITS-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] out_value, [25:16] out_column, [37:26] out_row, [39:38] zero
  output logic [bb3_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int PW    = bb3_pkg::eff_pix_bits(PIXEL_BITS);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = bb3_pkg::WIDTH_W;
  localparam int HW    = bb3_pkg::HEIGHT_W;
  localparam int RW    = bb3_pkg::ROW_W;
  localparam int CX    = ((COL_W > WW) ? COL_W : WW) + 1;
  localparam int WRST  = (bb3_pkg::WIDTH_RST < MAX_WIDTH) ? bb3_pkg::WIDTH_RST : MAX_WIDTH;

  logic [WW-1:0]    width_q, width_d;
  logic [HW-1:0]    height_q, height_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [RW-1:0]    row_q, row_d;

  logic             cfg_wr, s_acc, last_col, last_row;
  logic [WW-1:0]    wv;
  logic [HW-1:0]    hv;
  bb3_pkg::res_ctl_t ctl_in;

  // stage 1
  logic              s1_valid_q, s1_fwd_q;
  logic [PW-1:0]     s1_p_q, fwd_o_q, fwd_r_q, mem_o_q, mem_r_q;
  logic [COL_W-1:0]  s1_x_q;
  logic [RW-1:0]     s1_y_q;
  bb3_pkg::res_ctl_t s1_ctl_q;
  logic              s1_adv, emit_ready;
  logic [PW-1:0]     o_eff, r_eff;

  logic [PW-1:0] older_mem  [MAX_WIDTH];
  logic [PW-1:0] recent_mem [MAX_WIDTH];

  logic [PW-1:0] c0_o, c0_r, c0_p, c1_o, c1_r, c1_p;
  logic [PW+1:0] c0_sum, c1_sum;
  logic [PW+3:0] win_sum;
  logic [COL_W-1:0] w_m1;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = !s1_valid_q || emit_ready;
  assign s_acc       = s_axis_tvalid && s_axis_tready;

  assign wv = cfg_data_i[WW-1:0];
  assign hv = cfg_data_i[HW-1:0];

  assign last_col = (CX'(col_q) + CX'(1)) == CX'(width_q);
  assign last_row = ((HW)'(row_q) + HW'(1)) == height_q;

  always_comb begin
    ctl_in.need_a   = (row_q >= RW'(2)) && (col_q != '0);
    ctl_in.a_direct = (col_q == COL_W'(1));
    ctl_in.need_b   = (row_q >= RW'(2)) && last_col;
    ctl_in.need_c   = (row_q == '0) || last_row;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_wr && (cfg_index_i == bb3_pkg::REG_IMAGE_WIDTH ||
                   cfg_index_i == bb3_pkg::REG_IMAGE_HEIGHT)) begin
      if (cfg_index_i == bb3_pkg::REG_IMAGE_WIDTH) begin
        if (wv == '0) begin
          width_d = WW'(1);
        end else if (int'(wv) > MAX_WIDTH) begin
          width_d = WW'(MAX_WIDTH);
        end else begin
          width_d = wv;
        end
      end else begin
        if (hv == '0) begin
          height_d = HW'(1);
        end else if (int'(hv) > bb3_pkg::MAX_HEIGHT) begin
          height_d = HW'(bb3_pkg::MAX_HEIGHT);
        end else begin
          height_d = hv;
        end
      end
      col_d = '0;
      row_d = '0;
    end else if (s_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WW'(WRST);
      height_q   <= HW'(bb3_pkg::HEIGHT_RST);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
    end
  end

  // line stores; same-address write in the transfer cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      mem_o_q  <= older_mem[col_q];
      mem_r_q  <= recent_mem[col_q];
      s1_fwd_q <= s1_adv && (s1_x_q == col_q);
      fwd_o_q  <= r_eff;
      fwd_r_q  <= s1_p_q;
      s1_p_q   <= s_axis_tdata[PW-1:0];
      s1_x_q   <= col_q;
      s1_y_q   <= row_q;
      s1_ctl_q <= ctl_in;
    end
    if (s1_adv) begin
      older_mem[s1_x_q]  <= r_eff;
      recent_mem[s1_x_q] <= s1_p_q;
    end
  end

  assign s1_adv = s1_valid_q && emit_ready;
  assign o_eff  = s1_fwd_q ? fwd_o_q : mem_o_q;
  assign r_eff  = s1_fwd_q ? fwd_r_q : mem_r_q;

  bb3_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell1 (
    .clk_i, .rst_ni, .shift_i(s1_adv),
    .o_i(o_eff), .r_i(r_eff), .p_i(s1_p_q),
    .o_o(c1_o), .r_o(c1_r), .p_o(c1_p), .sum_o(c1_sum)
  );

  bb3_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell0 (
    .clk_i, .rst_ni, .shift_i(s1_adv),
    .o_i(c1_o), .r_i(c1_r), .p_i(c1_p),
    .o_o(c0_o), .r_o(c0_r), .p_o(c0_p), .sum_o(c0_sum)
  );

  assign win_sum = (PW+4)'(c0_sum) + (PW+4)'(c1_sum) + (PW+4)'(o_eff) +
                   (PW+4)'(r_eff) + (PW+4)'(s1_p_q) + (PW+4)'(4);
  assign w_m1 = COL_W'(CX'(width_q) - CX'(1));

  bb3_emit #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_emit (
    .clk_i, .rst_ni,
    .in_valid_i(s1_valid_q), .in_ready_o(emit_ready),
    .ctl_i(s1_ctl_q), .sum_i(win_sum), .va_direct_i(c1_r),
    .vb_i(r_eff), .vc_i(s1_p_q),
    .x_i(s1_x_q), .y_i(s1_y_q), .w_m1_i(w_m1),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CX'(col_q) < CX'(width_q))
    else $error("column counter beyond image width");

  a_fwd_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_q) |-> s1_x_q == '0)
    else $error("line store forward on a non-zero column");

  a_acc_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !emit_ready) |-> !s_axis_tready)
    else $error("input taken while window stage stalled");

  a_c0_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c0_sum === (PW+2)'(c0_o) + (PW+2)'(c0_r) + (PW+2)'(c0_p))
    else $error("end cell sum out of step with its pixels");

endmodule

// File: src/bb3_cell.sv
// One window column cell: older, recent and current pixel plus their sum.
// Depends on bb3_pkg.
module bb3_cell #(
  parameter int PIXEL_BITS = bb3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        shift_i,
  input  logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] o_i,
  input  logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] r_i,
  input  logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] p_i,
  output logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] o_o,
  output logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] r_o,
  output logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] p_o,
  output logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)+1:0] sum_o
);

  localparam int PW = bb3_pkg::eff_pix_bits(PIXEL_BITS);

  logic [PW-1:0] o_q, r_q, p_q;
  logic [PW+1:0] sum_q, sum_d;

  assign sum_d = (PW+2)'(o_i) + (PW+2)'(r_i) + (PW+2)'(p_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_q   <= '0;
      r_q   <= '0;
      p_q   <= '0;
      sum_q <= '0;
    end else if (shift_i) begin
      o_q   <= o_i;
      r_q   <= r_i;
      p_q   <= p_i;
      sum_q <= sum_d;
    end
  end

  assign o_o   = o_q;
  assign r_o   = r_q;
  assign p_o   = p_q;
  assign sum_o = sum_q;

endmodule

// File: src/bb3_emit.sv
// Divide-by-nine stage and result serialiser feeding the output stream.
// Depends on bb3_pkg.
module bb3_emit #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bb3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  bb3_pkg::res_ctl_t                           ctl_i,
  input  logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)+3:0] sum_i,
  input  logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] va_direct_i,
  input  logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] vb_i,
  input  logic [bb3_pkg::eff_pix_bits(PIXEL_BITS)-1:0] vc_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]                x_i,
  input  logic [bb3_pkg::ROW_W-1:0]                   y_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]                w_m1_i,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // [15:0] out_value, [25:16] out_column, [37:26] out_row, [39:38] zero
  output logic [bb3_pkg::OUT_DATA_W-1:0]              m_axis_tdata,
  output logic                                        m_axis_tlast
);

  localparam int PW = bb3_pkg::eff_pix_bits(PIXEL_BITS);
  localparam int SW = PW + 4;
  localparam int K  = PW + 8;
  localparam int MW = K - 3;
  localparam logic [MW-1:0] RECIP = MW'((2**K + 8) / 9);
  localparam int CW = bb3_pkg::COL_OUT_W;
  localparam int RW = bb3_pkg::ROW_W;

  // stage 2: sum and candidates
  logic          s2_valid_q;
  logic [2:0]    s2_mask_q;
  logic          s2_dir_q;
  logic [SW-1:0] s2_sum_q;
  logic [PW-1:0] s2_vdir_q, s2_vb_q, s2_vc_q;
  logic [CW-1:0] s2_col_a_q, s2_col_b_q, s2_col_c_q;
  logic [RW-1:0] s2_row_ab_q, s2_row_c_q;

  // stage 3: output register
  logic          s3_valid_q;
  logic [2:0]    s3_mask_q;
  logic [PW-1:0] s3_va_q, s3_vb_q, s3_vc_q;
  logic [CW-1:0] s3_col_a_q, s3_col_b_q, s3_col_c_q;
  logic [RW-1:0] s3_row_ab_q, s3_row_c_q;

  logic [SW+MW-1:0] prod;
  logic [PW-1:0]    quot, va;
  logic             last_res, s3_xfer, s3_free, s2_leave, s3_load, s2_free;
  logic [2:0]       mask_next;
  logic [PW-1:0]    sel_v;
  logic [CW-1:0]    sel_col;
  logic [RW-1:0]    sel_row;

  assign prod = (SW+MW)'(s2_sum_q) * (SW+MW)'(RECIP);
  assign quot = prod[K+PW-1:K];
  assign va   = s2_dir_q ? s2_vdir_q : quot;

  assign mask_next = s3_mask_q & (s3_mask_q - 3'd1);
  assign last_res  = (mask_next == 3'd0);
  assign s3_xfer   = s3_valid_q && m_axis_tready;
  assign s3_free   = !s3_valid_q || (s3_xfer && last_res);
  assign s2_leave  = s2_valid_q && ((s2_mask_q == 3'd0) || s3_free);
  assign s3_load   = s2_valid_q && (s2_mask_q != 3'd0) && s3_free;
  assign s2_free   = !s2_valid_q || s2_leave;
  assign in_ready_o = s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s3_mask_q  <= 3'd0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= in_valid_i;
      end
      if (s3_load) begin
        s3_valid_q <= 1'b1;
        s3_mask_q  <= s2_mask_q;
      end else if (s3_xfer) begin
        s3_valid_q <= !last_res;
        s3_mask_q  <= mask_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && in_valid_i) begin
      s2_mask_q   <= {ctl_i.need_c, ctl_i.need_b, ctl_i.need_a};
      s2_dir_q    <= ctl_i.a_direct;
      s2_sum_q    <= sum_i;
      s2_vdir_q   <= va_direct_i;
      s2_vb_q     <= vb_i;
      s2_vc_q     <= vc_i;
      s2_col_a_q  <= CW'(x_i - 1'b1);
      s2_col_b_q  <= CW'(w_m1_i);
      s2_col_c_q  <= CW'(x_i);
      s2_row_ab_q <= y_i - 1'b1;
      s2_row_c_q  <= y_i;
    end
    if (s3_load) begin
      s3_va_q     <= va;
      s3_vb_q     <= s2_vb_q;
      s3_vc_q     <= s2_vc_q;
      s3_col_a_q  <= s2_col_a_q;
      s3_col_b_q  <= s2_col_b_q;
      s3_col_c_q  <= s2_col_c_q;
      s3_row_ab_q <= s2_row_ab_q;
      s3_row_c_q  <= s2_row_c_q;
    end
  end

  always_comb begin
    if (s3_mask_q[0]) begin
      sel_v   = s3_va_q;
      sel_col = s3_col_a_q;
      sel_row = s3_row_ab_q;
    end else if (s3_mask_q[1]) begin
      sel_v   = s3_vb_q;
      sel_col = s3_col_b_q;
      sel_row = s3_row_ab_q;
    end else begin
      sel_v   = s3_vc_q;
      sel_col = s3_col_c_q;
      sel_row = s3_row_c_q;
    end
  end

  assign m_axis_tvalid = s3_valid_q;
  assign m_axis_tlast  = last_res;
  assign m_axis_tdata  = {2'b00, sel_row, sel_col, 16'(sel_v)};

  a_s3_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> s3_mask_q != 3'd0)
    else $error("output stage valid with no pending result");

  a_s3_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !m_axis_tready) |=> s3_valid_q && $stable(s3_mask_q))
    else $error("pending results changed during stall");

endmodule

// File: test/box_blur_3x3_tb.sv
// Self-checking bench for box_blur_3x3: directed plan then random frames, with
// a cycle-free predictor of the 3x3 mean filter scoring every output transfer.
// Depends on bb3_pkg and the box_blur_3x3 RTL only.
`timescale 1ns / 100ps

module box_blur_3x3_tb;

  localparam int ITEMS        = 360;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 280;
  localparam int STEADY_FROM  = 120;
  localparam int STEADY_TO    = 200;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PRINT_LIMIT  = 40;

  localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [15:0] value;
    logic [9:0]  col;
    logic [11:0] row;
    logic        last;
  } out_px_t;

  typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_e;

  typedef struct packed {
    step_kind_e                     kind;
    logic [bb3_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [bb3_pkg::CFG_DATA_W-1:0] reg_data;
    logic [15:0]                    pix;
    logic                           typed;
    out_px_t                        want;
  } plan_step_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [bb3_pkg::IN_BITS-1:0]    s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [bb3_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  box_blur_3x3 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [15:0] prev2_line [0:bb3_pkg::MAX_WIDTH_DEF-1];
  logic [15:0] prev_line  [0:bb3_pkg::MAX_WIDTH_DEF-1];
  logic [15:0] win [0:5];
  int          x_pos, y_pos;
  int          cur_width, cur_height;

  out_px_t     blur_out[$];
  out_px_t     blurred_due[$];
  plan_step_t  plan[$];

  int pix_planned, gen_w, gen_h, geometries;
  int pix_sent, results_seen, reg_writes, errors;
  int quiet_cycles, hold_left, hold_done, hold_asks;
  logic steady = 1'b0;

  function automatic int eff_width(input logic [bb3_pkg::CFG_DATA_W-1:0] data);
    int v;
    v = data[bb3_pkg::WIDTH_W-1:0];
    if (v == 0) v = 1;
    if (v > bb3_pkg::MAX_WIDTH_DEF) v = bb3_pkg::MAX_WIDTH_DEF;
    return v;
  endfunction

  function automatic int eff_height(input logic [bb3_pkg::CFG_DATA_W-1:0] data);
    int v;
    v = data[bb3_pkg::HEIGHT_W-1:0];
    if (v == 0) v = 1;
    if (v > bb3_pkg::MAX_HEIGHT) v = bb3_pkg::MAX_HEIGHT;
    return v;
  endfunction

  function automatic out_px_t make_px(input logic [15:0] v, input int c, input int r);
    out_px_t p;
    p.value = v;
    p.col   = 10'(c);
    p.row   = 12'(r);
    p.last  = 1'b0;
    return p;
  endfunction

  function automatic logic [15:0] any_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit in_steady_span();
    return pix_sent >= STEADY_FROM && pix_sent < STEADY_TO;
  endfunction

  task automatic apply_reg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bb3_pkg::CFG_DATA_W-1:0] data);
    if (idx == bb3_pkg::REG_IMAGE_WIDTH) cur_width = eff_width(data);
    else if (idx == bb3_pkg::REG_IMAGE_HEIGHT) cur_height = eff_height(data);
    else return;
    x_pos = 0;
    y_pos = 0;
  endtask

  // fills blur_out with the results owed by one pixel, in emission order
  task automatic blur_pixel(input logic [15:0] pix);
    int x, y, sum;
    logic [15:0] above2, above1, val;
    out_px_t tail;
    x = x_pos;
    y = y_pos;
    above2 = prev2_line[x];
    above1 = prev_line[x];
    blur_out.delete();
    if (y >= 2 && x >= 1) begin
      if (x == 1) begin
        val = win[3];
      end else begin
        sum = win[0] + win[1] + win[2] + win[3] + win[4] + win[5] + above2 + above1 + pix;
        val = 16'((sum + 4) / 9);
      end
      blur_out.push_back(make_px(val, x - 1, y - 1));
    end
    if (y >= 2 && x + 1 == cur_width) blur_out.push_back(make_px(above1, cur_width - 1, y - 1));
    if (y == 0 || y + 1 == cur_height) blur_out.push_back(make_px(pix, x, y));
    if (blur_out.size() != 0) begin
      tail = blur_out.pop_back();
      tail.last = 1'b1;
      blur_out.push_back(tail);
    end
    win[0] = win[1];
    win[1] = above2;
    win[2] = win[3];
    win[3] = above1;
    win[4] = win[5];
    win[5] = pix;
    prev2_line[x] = above1;
    prev_line[x] = pix;
    if (x + 1 >= cur_width) begin
      x_pos = 0;
      y_pos = (y + 1 >= cur_height) ? 0 : y + 1;
    end else begin
      x_pos = x + 1;
    end
  endtask

  task automatic add_reg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                         input logic [bb3_pkg::CFG_DATA_W-1:0] data);
    plan_step_t s;
    s = '0;
    s.kind = STEP_REG;
    s.reg_idx = idx;
    s.reg_data = data;
    plan.push_back(s);
    if (idx == bb3_pkg::REG_IMAGE_WIDTH) gen_w = eff_width(data);
    if (idx == bb3_pkg::REG_IMAGE_HEIGHT) gen_h = eff_height(data);
  endtask

  task automatic add_pix(input logic [15:0] p);
    plan_step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.pix = p;
    plan.push_back(s);
    pix_planned++;
  endtask

  // pixel whose only result is itself, copied at (c, r)
  task automatic add_copy(input logic [15:0] p, input int c, input int r);
    plan_step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.pix = p;
    s.typed = 1'b1;
    s.want = make_px(p, c, r);
    s.want.last = 1'b1;
    plan.push_back(s);
    pix_planned++;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("mismatch %0s at result %0d: got 0x%0h, expected 0x%0h",
               what, results_seen, got, want);
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (blurred_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_pixel(input plan_step_t s);
    while (!in_steady_span() && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s.pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    blur_pixel(s.pix);
    if (s.typed) begin
      blurred_due.push_back(s.want);
    end else begin
      foreach (blur_out[k]) blurred_due.push_back(blur_out[k]);
    end
    pix_sent++;
  endtask

  // receiver: random back-pressure, one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk_i) begin : check_out
    out_px_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (blurred_due.size() == 0) begin
        flag_mismatch("transfer with nothing pending", m_axis_tdata[15:0], 0);
      end else begin
        want = blurred_due.pop_front();
        if (m_axis_tdata[15:0] !== want.value)
          flag_mismatch("out_value", m_axis_tdata[15:0], want.value);
        if (m_axis_tdata[25:16] !== want.col)
          flag_mismatch("out_column", m_axis_tdata[25:16], want.col);
        if (m_axis_tdata[37:26] !== want.row)
          flag_mismatch("out_row", m_axis_tdata[37:26], want.row);
        if (m_axis_tlast !== want.last)
          flag_mismatch("tlast", m_axis_tlast, want.last);
        if (m_axis_tdata[39:38] !== 2'b00)
          flag_mismatch("tdata pad", m_axis_tdata[39:38], 0);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, blurred_due.size());
      $display("box_blur_3x3 test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int mode, sel, w, h, fsize, n, half;
    logic [bb3_pkg::CFG_DATA_W-1:0] wdata, hdata;
    plan_step_t s;

    foreach (prev_line[k]) begin
      prev_line[k]  = '0;
      prev2_line[k] = '0;
    end
    foreach (win[k]) win[k] = '0;
    x_pos = 0;
    y_pos = 0;
    cur_width  = bb3_pkg::WIDTH_RST;
    cur_height = bb3_pkg::HEIGHT_RST;
    gen_w = bb3_pkg::WIDTH_RST;
    gen_h = bb3_pkg::HEIGHT_RST;

    // directed: reset geometry, zero and oversize registers, narrow, short
    add_copy(16'hFFFF, 0, 0);
    add_copy(16'h0000, 1, 0);
    add_reg(bb3_pkg::REG_IMAGE_WIDTH, 13'd0);
    add_reg(bb3_pkg::REG_IMAGE_HEIGHT, 13'd0);
    add_copy(16'hFFFF, 0, 0);
    add_copy(16'h8001, 0, 0);
    add_reg(bb3_pkg::REG_IMAGE_WIDTH, 13'h0803);
    add_reg(bb3_pkg::REG_IMAGE_HEIGHT, 13'd3);
    repeat (9) add_pix(16'hFFFF);
    add_reg(bb3_pkg::REG_IMAGE_WIDTH, 13'd2);
    add_reg(bb3_pkg::REG_IMAGE_HEIGHT, 13'd2);
    add_copy(16'h0001, 0, 0);
    add_copy(16'h8000, 1, 0);
    add_copy(16'h7FFF, 0, 1);
    add_copy(16'hFFFE, 1, 1);
    add_reg(bb3_pkg::REG_IMAGE_WIDTH, 13'd2047);
    add_reg(bb3_pkg::REG_IMAGE_HEIGHT, 13'd8191);
    add_copy(16'h5555, 0, 0);
    add_copy(16'hAAAA, 1, 0);
    add_copy(16'h0F0F, 2, 0);
    add_reg(bb3_pkg::REG_IMAGE_WIDTH, 13'd1);
    add_reg(bb3_pkg::REG_IMAGE_HEIGHT, 13'd4);
    add_pix(16'h1111);
    add_pix(16'h2222);
    // unused indexes must not restart the frame
    add_reg(REG_SPARE_2, 13'h1555);
    add_reg(REG_SPARE_3, 13'h0AAA);
    add_pix(16'h3333);
    add_pix(16'h4444);
    geometries = 6;

    while (pix_planned < ITEMS) begin
      mode = $urandom_range(0, 11);
      case (mode)
        6, 7: begin
          w = $urandom_range(1, 2);
          h = $urandom_range(1, 8);
        end
        8: begin
          w = $urandom_range(3, 10);
          h = $urandom_range(1, 2);
        end
        9, 10: begin
          w = $urandom_range(3, 8);
          h = $urandom_range(3, 8);
        end
        default: begin
          w = $urandom_range(3, 10);
          h = $urandom_range(3, 6);
        end
      endcase
      wdata = {2'($urandom_range(0, 3)), 11'(w)};
      hdata = 13'(h);
      if (mode == 11 && $urandom_range(0, 1) == 0) begin
        wdata = 13'($urandom);
        hdata = 13'($urandom_range(bb3_pkg::MAX_HEIGHT, 8191));
      end
      sel = $urandom_range(0, 5);
      if (sel != 1) add_reg(bb3_pkg::REG_IMAGE_WIDTH, wdata);
      if (sel != 0) add_reg(bb3_pkg::REG_IMAGE_HEIGHT, hdata);
      geometries++;
      fsize = gen_w * gen_h;
      if (fsize > 64) begin
        n = $urandom_range(20, 40);
      end else begin
        n = fsize * $urandom_range(1, 2);
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      end
      if (n > ITEMS - pix_planned) n = ITEMS - pix_planned;
      half = ($urandom_range(0, 7) == 0) ? n / 2 : -1;
      for (int k = 0; k < n; k++) begin
        if (k == half)
          add_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_3 : REG_SPARE_2, 13'($urandom));
        add_pix(any_pixel());
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < plan.size(); i++) begin
      s = plan[i];
      if (s.kind == STEP_REG) begin
        if (i == 0 || plan[i-1].kind != STEP_REG) settle_block();
        cfg_valid_i <= 1'b1;
        cfg_index_i <= s.reg_idx;
        cfg_data_i  <= s.reg_data;
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        apply_reg(s.reg_idx, s.reg_data);
        reg_writes++;
        if (i + 1 == plan.size() || plan[i+1].kind != STEP_REG) cfg_valid_i <= 1'b0;
      end else begin
        steady <= in_steady_span();
        if (pix_sent == HOLD_AT) hold_asks <= hold_asks + 1;
        send_pixel(s);
      end
    end

    settle_block();
    $display("covered %0d pixels over %0d geometry settings with %0d register writes",
             pix_sent, geometries, reg_writes);
    $display("compared %0d filtered and copied results, %0d mismatches",
             results_seen, errors);
    if (errors == 0) begin
      $display("box_blur_3x3 test passed");
    end else begin
      $display("box_blur_3x3 test failed");
    end
    $finish;
  end

endmodule
